// ----- rtl/cvg_pkg.sv -----
`timescale 1ns / 1ps

package cvg_pkg;

  localparam int MaxWidth     = 4096;
  localparam int MaxHeight    = 4096;
  localparam int CoefBits     = 16;
  localparam int CoefFracBits = 8;
  localparam int PixW         = 8;
  localparam int PosW         = 12;
  localparam int DimW         = 13;
  localparam int CoefRegW     = 48;
  localparam int CfgIdxW      = 3;
  localparam int ProdW        = CoefBits + PixW + 1;
  localparam int AccW         = ProdW + 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 3'd0,
    CfgImageHeight = 3'd1,
    CfgCoefTop     = 3'd2,
    CfgCoefMid     = 3'd3,
    CfgCoefBot     = 3'd4
  } cfg_reg_e;

  typedef logic        [PixW-1:0]     pix_t;
  typedef logic        [PosW-1:0]     pos_t;
  typedef logic        [DimW-1:0]     dim_t;
  typedef logic        [CoefRegW-1:0] coef_row_t;
  typedef logic signed [CoefBits-1:0] coef_t;
  typedef logic signed [ProdW-1:0]    prod_t;
  typedef logic signed [AccW-1:0]     acc_t;

  localparam dim_t      WidthReset   = 13'd640;
  localparam dim_t      HeightReset  = 13'd480;
  localparam coef_row_t CoefTopReset = 48'd0;
  localparam coef_row_t CoefMidReset = 48'd16777216;
  localparam coef_row_t CoefBotReset = 48'd0;
  localparam dim_t      DimMin       = 13'd3;
  localparam acc_t      ClampTop     = acc_t'(255 * (2 ** CoefFracBits));
  localparam pix_t      PixMax       = 8'd255;

endpackage

// ----- rtl/cvg_if.sv -----
`timescale 1ns / 1ps

interface cvg_pix_if;
  import cvg_pkg::*;

  logic       valid;
  logic       ready;
  pix_t       pixel_in;
  logic       frame_start;

  modport source (output valid, pixel_in, frame_start, input ready);
  modport sink   (input valid, pixel_in, frame_start, output ready);
endinterface

interface cvg_res_if;
  import cvg_pkg::*;

  logic       valid;
  logic       ready;
  pos_t       out_col;
  pos_t       out_row;
  pix_t       pixel_out;
  logic       frame_last;

  modport source (output valid, out_col, out_row, pixel_out, frame_last, input ready);
  modport sink   (input valid, out_col, out_row, pixel_out, frame_last, output ready);
endinterface

// ----- rtl/conv3x3_gray_clamp.sv -----
`timescale 1ns / 1ps

// 3x3 convolution over an 8-bit grayscale pixel stream.
// Pixels enter in raster order on pix_i (valid/ready); frame_start marks column 0, row 0.
// Each pixel at column x >= 2 and row y >= 2 yields one result on res_o for the
// centre pixel (x-1, y-1); border pixels yield none. frame_last flags the last result.
// Nine signed Q8.8 taps come from coef rows top/mid/bot; the sum clamps to 0..255.
// Configuration writes through cfg_we_i/cfg_idx_i/cfg_data_i; the user must make them only
// while the block is idle; the block does not enforce it. Throughput: one pixel per clock
// while res_o does not stall; the pipeline runs line-store read and nine parallel multiplies,
// then adder tree and clamp. The two 4096 x 8 line stores have one read and one write port
// each; their contents are undefined after reset and need no clearing.
// Reset: rst_ni clears position counters, window, pipeline valids and registers to
// width 640, height 480, identity taps. When res_o stalls, results wait in the output
// register and pipeline; pix_i.ready drops only once every stage is full.

module conv3x3_gray_clamp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cvg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cvg_pkg::CoefRegW-1:0] cfg_data_i,
  cvg_pix_if.sink                      pix_i,
  cvg_res_if.source                    res_o
);
  import cvg_pkg::*;

  dim_t                 width_q, height_q;
  logic [2:0][CoefRegW-1:0] coef_q;
  dim_t                 w_eff, h_eff;

  pos_t                 col_q, row_q, col_d, row_d;
  pos_t                 x, y;
  dim_t                 x_inc, y_inc;
  logic                 in_acc, emit, last;

  logic                 s1_v_q, s1_emit_q, s1_last_q, s1_adv, s1_fire;
  pix_t                 s1_px_q;
  pos_t                 s1_x_q, s1_y_q;
  pix_t                 rd_old, rd_new;
  logic [5:0][PixW-1:0] win_q;
  pix_t                 colv [3];
  prod_t                prod [9];

  logic                 s2_v_q, s2_last_q, s2_adv;
  pos_t                 s2_col_q, s2_row_q;
  prod_t                s2_prod_q [9];
  acc_t                 acc;
  pix_t                 clamp_px;

  logic                 out_v_q, out_last_q, out_adv;
  pos_t                 out_col_q, out_row_q;
  pix_t                 out_px_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      coef_q   <= {CoefBotReset, CoefMidReset, CoefTopReset};
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgImageWidth:  width_q   <= cfg_data_i[DimW-1:0];
        CfgImageHeight: height_q  <= cfg_data_i[DimW-1:0];
        CfgCoefTop:     coef_q[0] <= cfg_data_i;
        CfgCoefMid:     coef_q[1] <= cfg_data_i;
        CfgCoefBot:     coef_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < DimMin) begin
      w_eff = DimMin;
    end else if (width_q > dim_t'(MaxWidth)) begin
      w_eff = dim_t'(MaxWidth);
    end else begin
      w_eff = width_q;
    end
    if (height_q < DimMin) begin
      h_eff = DimMin;
    end else if (height_q > dim_t'(MaxHeight)) begin
      h_eff = dim_t'(MaxHeight);
    end else begin
      h_eff = height_q;
    end
  end

  assign in_acc      = pix_i.valid && pix_i.ready;
  assign pix_i.ready = s1_adv;

  always_comb begin
    x     = pix_i.frame_start ? '0 : col_q;
    y     = pix_i.frame_start ? '0 : row_q;
    emit  = (x >= pos_t'(2)) && (y >= pos_t'(2)) &&
            (dim_t'(x) < w_eff) && (dim_t'(y) < h_eff);
    last  = (dim_t'(x) == w_eff - 1'b1) && (dim_t'(y) == h_eff - 1'b1);
    x_inc = dim_t'(x) + 1'b1;
    y_inc = dim_t'(y) + 1'b1;
    col_d = x_inc[PosW-1:0];
    row_d = y;
    if (x_inc >= w_eff) begin
      col_d = '0;
      row_d = (y_inc >= h_eff) ? '0 : y_inc[PosW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign s1_adv  = !s1_v_q || s2_adv;
  assign s1_fire = s1_v_q && s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_adv) begin
      s1_v_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_emit_q <= emit;
      s1_last_q <= last;
      s1_px_q   <= pix_i.pixel_in;
      s1_x_q    <= x;
      s1_y_q    <= y;
    end
  end

  cvg_ram #(
    .Width (PixW),
    .Depth (MaxWidth)
  ) u_line_older (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_x_q),
    .wdata_i (rd_new),
    .re_i    (in_acc),
    .raddr_i (x),
    .rdata_o (rd_old)
  );

  cvg_ram #(
    .Width (PixW),
    .Depth (MaxWidth)
  ) u_line_newer (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_x_q),
    .wdata_i (s1_px_q),
    .re_i    (in_acc),
    .raddr_i (x),
    .rdata_o (rd_new)
  );

  assign colv[0] = rd_old;
  assign colv[1] = rd_new;
  assign colv[2] = s1_px_q;

  // shift the window one column left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_fire) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*2]   <= win_q[r*2+1];
        win_q[r*2+1] <= colv[r];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod[r*3]   = prod_t'(coef_t'(coef_q[r][0 +: CoefBits])) *
                    prod_t'({1'b0, win_q[r*2]});
      prod[r*3+1] = prod_t'(coef_t'(coef_q[r][CoefBits +: CoefBits])) *
                    prod_t'({1'b0, win_q[r*2+1]});
      prod[r*3+2] = prod_t'(coef_t'(coef_q[r][2*CoefBits +: CoefBits])) *
                    prod_t'({1'b0, colv[r]});
    end
  end

  assign s2_adv = !s2_v_q || out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_adv) begin
      s2_v_q <= s1_v_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      s2_prod_q <= prod;
      s2_col_q  <= s1_x_q - 1'b1;
      s2_row_q  <= s1_y_q - 1'b1;
      s2_last_q <= s1_last_q;
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < 9; i++) begin
      acc = acc + acc_t'(s2_prod_q[i]);
    end
    if (acc > ClampTop) begin
      clamp_px = PixMax;
    end else if (acc < 0) begin
      clamp_px = '0;
    end else begin
      clamp_px = acc[CoefFracBits +: PixW];
    end
  end

  assign out_adv = !out_v_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_adv) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s2_v_q) begin
      out_col_q  <= s2_col_q;
      out_row_q  <= s2_row_q;
      out_px_q   <= clamp_px;
      out_last_q <= s2_last_q;
    end
  end

  assign res_o.valid      = out_v_q;
  assign res_o.out_col    = out_col_q;
  assign res_o.out_row    = out_row_q;
  assign res_o.pixel_out  = out_px_q;
  assign res_o.frame_last = out_last_q;

`ifndef NO_ASSERTIONS
  a_out_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.out_col != '0) && (res_o.out_row != '0))
    else $error("result on a border position");

  a_col_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !pix_i.frame_start && ((dim_t'(col_q) + 1'b1) < w_eff))
    |=> col_q == $past(col_q) + 1'b1)
    else $error("column counter failed to advance");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pix_i.frame_start) |=> (col_q == pos_t'(1)) && (row_q == '0))
    else $error("frame start did not restart position");

  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && !s2_adv) |=> s2_v_q)
    else $error("stalled result dropped");
`endif

endmodule

// ----- rtl/cvg_ram.sv -----
`timescale 1ns / 1ps

module cvg_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write-first on a same-address read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
